// File: sv/swsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Signed window scalar recoder package
// Shared constants, register codes, state structs and the window width helper.
// ----------------------------------------------------------------------------
package swsr_pkg;

    localparam int ScalarBytes = 32;
    localparam int ByteCntW    = $clog2(ScalarBytes);
    localparam int ByteW       = 8;
    localparam int BufW        = 18;
    localparam int HeldW       = 5;
    localparam int DigitW      = 11;
    localparam int IdxW        = 7;
    localparam int WinW        = 4;
    localparam int CntW        = 3;
    localparam int MaxDigits   = 4;

    localparam int CfgIdxW     = 1;
    localparam int CfgDataW    = 4;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] RegVariant    = 1'b0;
    localparam logic [CfgIdxW-1:0] RegWindowBits = 1'b1;

    // Variant codes.
    localparam logic VarRadix16 = 1'b0;
    localparam logic VarGeneral = 1'b1;

    localparam logic [WinW-1:0] WinRadix16 = 4'd4;
    localparam logic [WinW-1:0] WinMin     = 4'd2;
    localparam logic [WinW-1:0] WinMax     = 4'd11;
    localparam logic [WinW-1:0] WinReset   = 4'd5;
    localparam logic            VarReset   = VarGeneral;

    localparam logic [HeldW-1:0] HeldMax   = 5'd18;

    // Emitter state that feeds one digit step.
    typedef struct packed {
        logic [BufW-1:0]  bits;
        logic [HeldW-1:0] held;
        logic             carry;
        logic             final_byte;
        logic [CntW-1:0]  cnt;
        logic [WinW-1:0]  width;
        logic             variant;
    } t_step_in;

    // Outcome of one digit step.
    typedef struct packed {
        logic [DigitW-1:0] digit;
        logic              carry;
        logic [BufW-1:0]   bits;
        logic [HeldW-1:0]  held;
        logic              last;
        logic              more;
    } t_step_out;

    // Window width in use for a given register setting.
    function automatic logic [WinW-1:0] eff_width(input logic var_sel,
                                                  input logic [WinW-1:0] wbits);
        logic [WinW-1:0] w;
        w = wbits;
        if (var_sel == VarRadix16) begin
            w = WinRadix16;
        end else if (wbits < WinMin) begin
            w = WinMin;
        end else if (wbits > WinMax) begin
            w = WinMax;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// File: sv/swsr_digit_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Signed window digit step
// Takes one window off the bit buffer, folds in the carry and recodes it.
// ----------------------------------------------------------------------------
module swsr_digit_step (
    input  var swsr_pkg::t_step_in  i_st,
    output var swsr_pkg::t_step_out o_res
);

    logic [swsr_pkg::HeldW-1:0] c_w5;
    logic [swsr_pkg::HeldW-1:0] c_take;
    logic [swsr_pkg::HeldW-1:0] c_held;
    logic [11:0]                c_pow;
    logic [11:0]                c_mask;
    logic [11:0]                c_half;
    logic [11:0]                c_raw;
    logic [11:0]                c_sum;
    logic [11:0]                c_wrap;
    logic [11:0]                c_neg;
    logic                       c_last;
    logic [swsr_pkg::CntW-1:0]  c_cnt_nx;

    assign c_w5   = {1'b0, i_st.width};
    assign c_take = (i_st.held >= c_w5) ? c_w5 : i_st.held;
    assign c_held = i_st.held - c_take;
    assign c_last = i_st.final_byte && (c_held == '0);

    assign c_pow  = 12'd1 << i_st.width;
    assign c_mask = c_pow - 12'd1;
    assign c_half = 12'd1 << (i_st.width - 4'd1);
    assign c_raw  = {1'b0, i_st.bits[swsr_pkg::DigitW-1:0]} & c_mask;
    assign c_sum  = c_raw + {11'd0, i_st.carry};
    assign c_wrap = c_sum & c_mask;
    assign c_neg  = c_wrap - c_pow;
    assign c_cnt_nx = i_st.cnt + 3'd1;

    always_comb begin
        o_res.bits = i_st.bits >> c_take;
        o_res.held = c_held;
        o_res.last = c_last;
        o_res.more = ((c_held >= c_w5) || (i_st.final_byte && (c_held != '0)))
                     && (c_cnt_nx != 3'(swsr_pkg::MaxDigits));
        if ((i_st.variant == swsr_pkg::VarRadix16) && c_last) begin
            // The top radix-16 digit keeps its carry unreduced.
            o_res.digit = c_sum[swsr_pkg::DigitW-1:0];
            o_res.carry = 1'b0;
        end else if (c_wrap >= c_half) begin
            o_res.digit = c_neg[swsr_pkg::DigitW-1:0];
            o_res.carry = 1'b1;
        end else begin
            o_res.digit = c_wrap[swsr_pkg::DigitW-1:0];
            o_res.carry = c_sum[i_st.width];
        end
    end

endmodule
`default_nettype wire

// File: sv/signed_window_scalar_recoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Signed window scalar recoder
// Recodes a 256-bit scalar, fed a byte at a time, into signed radix-2^w digits.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) takes one scalar byte per word,
// least significant byte first, 32 words per scalar. The output channel
// (o_out_valid / i_out_ready) delivers one signed digit per word together with
// its index and a flag on the final digit of the scalar.
// An accepted byte is registered before its first digit moves to the output
// register. The emitter produces one digit per cycle, and a byte holds it
// until its digits are out, up to four at w = 2 and at most one for w of 8 or
// more, where a byte is taken every cycle; an output stall holds both. Only a
// scalar's final byte may yield a second digit there, to flush a partial digit.
// The next byte is taken in the same cycle that the last digit of the current
// one moves into the output register, so the stream runs without bubbles.
// When the receiver stalls, the finished digit waits in the output register;
// a byte that yields no digit is still taken, and the emitter stops only when
// it holds a digit that has nowhere to go.
// A synchronous reset (i_rst_n low) clears the buffer, carry and counters and
// restores variant = general and w = 5. Any configuration write also drops the
// scalar in progress; the next byte starts a new scalar.
// ----------------------------------------------------------------------------
module signed_window_scalar_recoder_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [swsr_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  wire  [swsr_pkg::CfgDataW-1:0]       i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [swsr_pkg::ByteW-1:0]          i_scalar_byte,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic signed [swsr_pkg::DigitW-1:0]  o_digit,
    output logic [swsr_pkg::IdxW-1:0]           o_digit_index,
    output logic                                o_last_digit
);

    // Configuration registers and the window width derived from them.
    logic                          r_variant;
    logic [swsr_pkg::WinW-1:0]     r_wbits;
    logic [swsr_pkg::WinW-1:0]     r_width;

    // Emitter state.
    logic [swsr_pkg::BufW-1:0]     r_bits,     n_bits;
    logic [swsr_pkg::HeldW-1:0]    r_held,     n_held;
    logic                          r_carry,    n_carry;
    logic                          r_final,    n_final;
    logic                          r_pend,     n_pend;
    logic [swsr_pkg::CntW-1:0]     r_cnt,      n_cnt;
    logic [swsr_pkg::ByteCntW-1:0] r_byte_cnt, n_byte_cnt;
    logic [swsr_pkg::IdxW-1:0]     r_dig_cnt,  n_dig_cnt;

    // Output register.
    logic                          r_o_vld;
    logic [swsr_pkg::DigitW-1:0]   r_o_digit;
    logic [swsr_pkg::IdxW-1:0]     r_o_idx;
    logic                          r_o_last;

    swsr_pkg::t_step_in            c_st;
    swsr_pkg::t_step_out           c_res;

    logic                          c_out_free;
    logic                          c_fire;
    logic                          c_scalar_end;
    logic                          c_take_in;
    logic [swsr_pkg::BufW-1:0]     c_base_bits;
    logic [swsr_pkg::HeldW-1:0]    c_base_held;
    logic [swsr_pkg::HeldW:0]      c_held_sum;
    logic [swsr_pkg::WinW-1:0]     c_cfg_width;

    assign c_st.bits       = r_bits;
    assign c_st.held       = r_held;
    assign c_st.carry      = r_carry;
    assign c_st.final_byte = r_final;
    assign c_st.cnt        = r_cnt;
    assign c_st.width      = r_width;
    assign c_st.variant    = r_variant;

    swsr_digit_step u_step (
        .i_st  (c_st),
        .o_res (c_res)
    );

    // A digit moves into the output register whenever one is pending and the
    // register is empty or being emptied in this cycle.
    assign c_out_free   = !r_o_vld || i_out_ready;
    assign c_fire       = r_pend && c_out_free;
    assign c_scalar_end = c_fire && !c_res.more && r_final;
    assign o_in_ready   = !r_pend || (c_fire && !c_res.more);
    assign c_take_in    = i_in_valid && o_in_ready;

    always_comb begin
        c_cfg_width = r_width;
        if (i_cfg_idx == swsr_pkg::RegVariant) begin
            c_cfg_width = swsr_pkg::eff_width(i_cfg_data[0], r_wbits);
        end else if (i_cfg_idx == swsr_pkg::RegWindowBits) begin
            c_cfg_width = swsr_pkg::eff_width(r_variant, i_cfg_data);
        end
    end

    always_comb begin
        n_bits     = r_bits;
        n_held     = r_held;
        n_carry    = r_carry;
        n_final    = r_final;
        n_pend     = r_pend;
        n_cnt      = r_cnt;
        n_byte_cnt = r_byte_cnt;
        n_dig_cnt  = r_dig_cnt;

        if (c_fire) begin
            n_bits    = c_res.bits;
            n_held    = c_res.held;
            n_carry   = c_res.carry;
            n_pend    = c_res.more;
            n_cnt     = r_cnt + 3'd1;
            n_dig_cnt = r_dig_cnt + 7'd1;
        end
        if (c_scalar_end) begin
            // The whole scalar is out: start the next one from a clean state.
            n_bits    = '0;
            n_held    = '0;
            n_carry   = 1'b0;
            n_final   = 1'b0;
            n_dig_cnt = '0;
        end

        c_base_bits = n_bits;
        c_base_held = n_held;
        c_held_sum  = {1'b0, c_base_held} + 6'd8;

        if (c_take_in) begin
            n_bits = c_base_bits
                     | (swsr_pkg::BufW'(i_scalar_byte) << c_base_held[3:0]);
            n_held = (c_held_sum > {1'b0, swsr_pkg::HeldMax})
                     ? swsr_pkg::HeldMax : c_held_sum[swsr_pkg::HeldW-1:0];
            n_final    = (r_byte_cnt == swsr_pkg::ByteCntW'(swsr_pkg::ScalarBytes - 1));
            n_byte_cnt = r_byte_cnt + 5'd1;
            n_cnt      = '0;
            // The final byte always flushes at least one digit.
            n_pend     = n_final || (n_held >= {1'b0, r_width});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant  <= swsr_pkg::VarReset;
            r_wbits    <= swsr_pkg::WinReset;
            r_width    <= swsr_pkg::WinReset;
            r_bits     <= '0;
            r_held     <= '0;
            r_carry    <= 1'b0;
            r_final    <= 1'b0;
            r_pend     <= 1'b0;
            r_cnt      <= '0;
            r_byte_cnt <= '0;
            r_dig_cnt  <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // Any write, to a known register or not, drops the scalar.
                if (i_cfg_idx == swsr_pkg::RegVariant) begin
                    r_variant <= i_cfg_data[0];
                end else if (i_cfg_idx == swsr_pkg::RegWindowBits) begin
                    r_wbits <= i_cfg_data;
                end
                r_width    <= c_cfg_width;
                r_bits     <= '0;
                r_held     <= '0;
                r_carry    <= 1'b0;
                r_final    <= 1'b0;
                r_pend     <= 1'b0;
                r_cnt      <= '0;
                r_byte_cnt <= '0;
                r_dig_cnt  <= '0;
            end else begin
                r_bits     <= n_bits;
                r_held     <= n_held;
                r_carry    <= n_carry;
                r_final    <= n_final;
                r_pend     <= n_pend;
                r_cnt      <= n_cnt;
                r_byte_cnt <= n_byte_cnt;
                r_dig_cnt  <= n_dig_cnt;
            end
            if (c_fire) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            r_o_digit <= c_res.digit;
            r_o_idx   <= r_dig_cnt;
            r_o_last  <= c_res.last;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_digit       = signed'(r_o_digit);
    assign o_digit_index = r_o_idx;
    assign o_last_digit  = r_o_last;

endmodule
`default_nettype wire

// File: sv/swsr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Signed window scalar recoder checker
// Watches the ports of the recoder for digit order, range and stall behavior.
// ----------------------------------------------------------------------------
module swsr_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_cfg_we,
    input wire [swsr_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input wire [swsr_pkg::CfgDataW-1:0]       i_cfg_data,
    input wire                                o_out_valid,
    input wire                                i_out_ready,
    input wire signed [swsr_pkg::DigitW-1:0]  o_digit,
    input wire [swsr_pkg::IdxW-1:0]           o_digit_index,
    input wire                                o_last_digit
);

    logic                         r_variant;
    logic [swsr_pkg::WinW-1:0]    r_wbits;
    logic [swsr_pkg::IdxW-1:0]    r_exp_idx;
    logic [swsr_pkg::WinW-1:0]    c_w;
    logic signed [11:0]           c_half;
    logic signed [11:0]           c_dig;

    assign c_w    = swsr_pkg::eff_width(r_variant, r_wbits);
    assign c_half = 12'sd1 <<< (c_w - 4'd1);
    assign c_dig  = o_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= swsr_pkg::VarReset;
            r_wbits   <= swsr_pkg::WinReset;
            r_exp_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == swsr_pkg::RegVariant) begin
                    r_variant <= i_cfg_data[0];
                end else if (i_cfg_idx == swsr_pkg::RegWindowBits) begin
                    r_wbits <= i_cfg_data;
                end
                r_exp_idx <= '0;
            end else if (o_out_valid && i_out_ready) begin
                r_exp_idx <= o_last_digit ? '0 : r_exp_idx + 7'd1;
            end
        end
    end

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A stalled digit stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_digit) && $stable(o_digit_index)
         && $stable(o_last_digit)))
        else $error("stalled digit changed");

    // Digits of a scalar come out in order from index zero.
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_index == r_exp_idx))
        else $error("digit index out of sequence");

    // Every reduced digit lies in the signed window range.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (!o_last_digit || (r_variant == swsr_pkg::VarGeneral)))
        |-> ((c_dig >= -c_half) && (c_dig < c_half)))
        else $error("digit outside the window range");

endmodule

bind signed_window_scalar_recoder_unit swsr_checker u_swsr_checker (.*);
`default_nettype wire
